>>> src/gwf_pkg.sv
// ----------------------------------------------------------------------------
// gwf_pkg
// Shared constants, codes, command/status types and helpers for the water
// flow block.
// ----------------------------------------------------------------------------
package gwf_pkg;

  localparam int GRID_W  = 64;
  localparam int GRID_H  = 64;
  localparam int X_W     = 6;
  localparam int Y_W     = 6;
  localparam int ADDR_W  = X_W + Y_W;
  localparam int CELLS   = GRID_W * GRID_H;
  localparam int WATER_W = 16;
  localparam int NEXT_W  = 19;   // accumulator: old water plus four inflows
  localparam int NUM_W   = 40;   // amount * (r2 - d256)
  localparam int DEN_W   = 24;   // r2
  localparam int QUOT_W  = 16;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] FL_FIRST  = ADDR_W'(GRID_W + 1);
  localparam logic [ADDR_W-1:0] FL_LAST   = ADDR_W'((GRID_H - 2) * GRID_W + GRID_W - 2);
  localparam logic [X_W-1:0]    FL_X_LAST = X_W'(GRID_W - 2);

  // operation kinds
  localparam logic [2:0] K_TERRAIN = 3'd0;
  localparam logic [2:0] K_RAIN    = 3'd1;
  localparam logic [2:0] K_RADIAL  = 3'd2;
  localparam logic [2:0] K_CLEAR   = 3'd3;
  localparam logic [2:0] K_FLOW    = 3'd4;
  localparam logic [2:0] K_READ    = 3'd5;

  // sweep modes
  localparam logic [2:0] MD_INIT  = 3'd0;
  localparam logic [2:0] MD_RAIN  = 3'd1;
  localparam logic [2:0] MD_CLEAR = 3'd2;
  localparam logic [2:0] MD_COPY  = 3'd3;
  localparam logic [2:0] MD_FIN   = 3'd4;

  // neighbor selects
  localparam logic [2:0] NB_CTR = 3'd0;
  localparam logic [2:0] NB_XP  = 3'd1;
  localparam logic [2:0] NB_XM  = 3'd2;
  localparam logic [2:0] NB_YP  = 3'd3;
  localparam logic [2:0] NB_YM  = 3'd4;

  // configuration register indexes
  localparam logic REG_SPEED = 1'b0;
  localparam logic REG_INFIL = 1'b1;

  typedef struct packed {
    logic              in_load;
    logic              sweep_en;
    logic [2:0]        mode;
    logic [ADDR_W-1:0] addr;
    logic              tw_we;
    logic              rd_water;
    logic              rr_init;
    logic              rr_cell;
    logic              rr_start;
    logic              rr_write;
    logic              fl_rd;
    logic              fl_ud_rd;
    logic              fl_ud_wr;
    logic [2:0]        nb;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       rr_in;
    logic       div_busy;
  } sts_t;

  function automatic logic [ADDR_W-1:0] nb_addr(input logic [ADDR_W-1:0] c,
                                                input logic [2:0] nb);
    logic [ADDR_W-1:0] r;
    case (nb)
      NB_XP:   r = c + ADDR_W'(1);
      NB_XM:   r = c - ADDR_W'(1);
      NB_YP:   r = c + ADDR_W'(GRID_W);
      NB_YM:   r = c - ADDR_W'(GRID_W);
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic [WATER_W-1:0] sat_add(input logic [WATER_W-1:0] a,
                                                 input logic [WATER_W-1:0] b);
    logic [WATER_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WATER_W] ? {WATER_W{1'b1}} : s[WATER_W-1:0];
  endfunction

endpackage

>>> src/gwf_div.sv
// ----------------------------------------------------------------------------
// gwf_div
// Restoring divider, one quotient bit per cycle. Quotient must fit QUOT_W.
// ----------------------------------------------------------------------------
module gwf_div import gwf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic              busy_o,
  output logic [QUOT_W-1:0] quot_o
);

  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [QUOT_W-1:0] low_q, low_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [DEN_W-1:0]  den_q;
  logic [4:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic [DEN_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, low_q[QUOT_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = num_i[NUM_W-1:QUOT_W];
      low_d  = num_i[QUOT_W-1:0];
      quot_d = '0;
      cnt_d  = 5'(QUOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      low_d  = {low_q[QUOT_W-2:0], 1'b0};
      quot_d = {quot_q[QUOT_W-2:0], fits};
      cnt_d  = cnt_q - 5'd1;
      busy_d = cnt_q != 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
    if (start_i) den_q <= den_i;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

>>> src/gwf_dp.sv
// ----------------------------------------------------------------------------
// gwf_dp
// Datapath: terrain, water and accumulator memories, flow and rain
// arithmetic, configuration registers and the result register.
// ----------------------------------------------------------------------------
module gwf_dp import gwf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [2:0]          in_kind_i,
  input  logic [X_W-1:0]      in_cell_x_i,
  input  logic [Y_W-1:0]      in_cell_y_i,
  input  logic signed [15:0]  in_terrain_height_i,
  input  logic [15:0]         in_rain_amount_i,
  input  logic [11:0]         in_rain_radius_i,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output logic [15:0]         out_water_level_o,
  output logic [2:0]          out_done_kind_o
);

  // memories
  logic [15:0]       terr_mem  [CELLS];
  logic [15:0]       water_mem [CELLS];
  logic [NEXT_W-1:0] next_mem  [CELLS];

  logic              t_re, w_re, n_re, t_we, w_we, n_we;
  logic [ADDR_W-1:0] t_raddr, w_raddr, n_raddr, t_waddr, w_waddr, n_waddr;
  logic [15:0]       t_wdata, w_wdata;
  logic [NEXT_W-1:0] n_wdata;
  logic [15:0]       t_rdata, w_rdata;
  logic [NEXT_W-1:0] n_rdata;

  // latched item and configuration
  logic [2:0]        kind_q;
  logic [X_W-1:0]    cx_q;
  logic [Y_W-1:0]    cy_q;
  logic [15:0]       th_q, amount_q;
  logic [11:0]       radius_q;
  logic [7:0]        speed_q;
  logic [15:0]       infil_q;

  // sweep stage
  logic              st_v_q;
  logic [2:0]        st_mode_q;
  logic [ADDR_W-1:0] st_addr_q;

  // flow
  logic              fl_v_q;
  logic [2:0]        fl_nb_q;
  logic signed [17:0] surf_c_q, surf;
  logic signed [18:0] diff;
  logic [15:0]       avail_q, out_q, fl_f;
  logic [15:0]       flow_q [4];
  logic [25:0]       fl_prod;
  logic [19:0]       fl_raw;
  logic              fl_go;
  logic [1:0]        fl_k, ud_k;
  logic [ADDR_W-1:0] nb_a;

  // finish and radial
  logic signed [19:0] fin_v;
  logic [15:0]       fin_w;
  logic [DEN_W-1:0]  r2_q;
  logic [20:0]       d256_q, d256;
  logic              rr_in_q;
  logic signed [6:0] ddx, ddy;
  logic signed [13:0] sqx, sqy;
  logic [12:0]       dsum;
  logic [NUM_W-1:0]  rr_num;
  logic              div_busy;
  logic [QUOT_W-1:0] quot;

  logic [15:0]       level_q;
  logic [2:0]        done_kind_q;

  assign nb_a  = nb_addr(cmd_i.addr, cmd_i.nb);

  assign surf  = $signed({{2{t_rdata[15]}}, t_rdata}) + $signed({2'b00, w_rdata});
  assign diff  = {surf_c_q[17], surf_c_q} - {surf[17], surf};
  assign fl_prod = 26'(diff[17:0]) * 26'(speed_q);
  assign fl_raw  = fl_prod[25:6];
  assign fl_f    = (fl_raw > {4'b0, avail_q}) ? avail_q : fl_raw[15:0];
  assign fl_go   = !diff[18] && (diff != '0) && (avail_q != '0);
  assign fl_k    = 2'(fl_nb_q - 3'd1);
  assign ud_k    = 2'(cmd_i.nb - 3'd1);

  assign fin_v = $signed({1'b0, n_rdata}) - $signed({4'b0, infil_q});
  assign fin_w = fin_v[19] ? 16'd0 : (fin_v[18:16] != '0) ? 16'hFFFF : fin_v[15:0];

  assign ddx  = $signed({1'b0, cmd_i.addr[X_W-1:0]}) - $signed({1'b0, cx_q});
  assign ddy  = $signed({1'b0, cmd_i.addr[ADDR_W-1:X_W]}) - $signed({1'b0, cy_q});
  assign sqx  = ddx * ddx;
  assign sqy  = ddy * ddy;
  assign dsum = 13'(sqx[11:0]) + 13'(sqy[11:0]);
  assign d256 = {dsum, 8'b0};
  assign rr_num = NUM_W'(amount_q) * NUM_W'(r2_q - {3'b0, d256_q});

  gwf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.rr_start),
    .num_i  (rr_num),
    .den_i  (r2_q),
    .busy_o (div_busy),
    .quot_o (quot)
  );

  // port steering
  always_comb begin
    t_re = 1'b0; w_re = 1'b0; n_re = 1'b0;
    t_raddr = nb_a; w_raddr = cmd_i.addr; n_raddr = cmd_i.addr;
    t_we = 1'b0; w_we = 1'b0; n_we = 1'b0;
    t_waddr = st_addr_q; w_waddr = st_addr_q; n_waddr = st_addr_q;
    t_wdata = '0; w_wdata = '0; n_wdata = '0;

    if (cmd_i.sweep_en) begin
      w_re = 1'b1;
      n_re = 1'b1;
    end
    if (cmd_i.rd_water) begin
      w_re = 1'b1;
      w_raddr = {cy_q, cx_q};
    end
    if (cmd_i.rr_cell) w_re = 1'b1;
    if (cmd_i.fl_rd) begin
      t_re = 1'b1;
      w_re = 1'b1;
      w_raddr = nb_a;
    end
    if (cmd_i.fl_ud_rd) begin
      n_re = 1'b1;
      n_raddr = nb_a;
    end

    if (st_v_q) begin
      case (st_mode_q)
        MD_INIT: begin
          t_we = 1'b1;
          w_we = 1'b1;
        end
        MD_RAIN: begin
          w_we = 1'b1;
          w_wdata = sat_add(w_rdata, amount_q);
        end
        MD_CLEAR: w_we = 1'b1;
        MD_COPY: begin
          n_we = 1'b1;
          n_wdata = NEXT_W'(w_rdata);
        end
        MD_FIN: begin
          w_we = 1'b1;
          w_wdata = fin_w;
        end
        default: ;
      endcase
    end
    if (cmd_i.tw_we) begin
      t_we = 1'b1;
      t_waddr = {cy_q, cx_q};
      t_wdata = th_q;
    end
    if (cmd_i.rr_write) begin
      w_we = 1'b1;
      w_waddr = cmd_i.addr;
      w_wdata = sat_add(w_rdata, quot);
    end
    if (cmd_i.fl_ud_wr) begin
      n_we = 1'b1;
      n_waddr = nb_a;
      n_wdata = (cmd_i.nb == NB_CTR) ? n_rdata - NEXT_W'(out_q)
                                     : n_rdata + NEXT_W'(flow_q[ud_k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (t_we) terr_mem[t_waddr] <= t_wdata;
    if (t_re) t_rdata <= terr_mem[t_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (w_we) water_mem[w_waddr] <= w_wdata;
    if (w_re) w_rdata <= water_mem[w_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (n_we) next_mem[n_waddr] <= n_wdata;
    if (n_re) n_rdata <= next_mem[n_raddr];
  end

  // control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q  <= 1'b0;
      fl_v_q  <= 1'b0;
      speed_q <= 8'd16;
      infil_q <= '0;
    end else begin
      st_v_q <= cmd_i.sweep_en;
      fl_v_q <= cmd_i.fl_rd;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_SPEED: speed_q <= cfg_data_i[7:0];
          REG_INFIL: infil_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    st_mode_q <= cmd_i.mode;
    st_addr_q <= cmd_i.addr;
    fl_nb_q   <= cmd_i.nb;
    if (cmd_i.in_load) begin
      kind_q   <= in_kind_i;
      cx_q     <= in_cell_x_i;
      cy_q     <= in_cell_y_i;
      th_q     <= in_terrain_height_i;
      amount_q <= in_rain_amount_i;
      radius_q <= in_rain_radius_i;
    end
    if (cmd_i.rr_init) r2_q <= DEN_W'(radius_q) * DEN_W'(radius_q);
    if (cmd_i.rr_cell) begin
      d256_q  <= d256;
      rr_in_q <= {3'b0, d256} < r2_q;
    end
    if (fl_v_q) begin
      if (fl_nb_q == NB_CTR) begin
        surf_c_q <= surf;
        avail_q  <= w_rdata;
        out_q    <= '0;
      end else if (fl_go) begin
        flow_q[fl_k] <= fl_f;
        avail_q      <= avail_q - fl_f;
        out_q        <= out_q + fl_f;
      end else begin
        flow_q[fl_k] <= '0;
      end
    end
    if (cmd_i.out_load) begin
      done_kind_q <= kind_q;
      level_q     <= (kind_q == K_READ) ? w_rdata : 16'd0;
    end
  end

  assign sts_o.kind     = kind_q;
  assign sts_o.rr_in    = rr_in_q;
  assign sts_o.div_busy = div_busy;

  assign out_water_level_o = level_q;
  assign out_done_kind_o   = done_kind_q;

endmodule

>>> src/gwf_ctrl.sv
// ----------------------------------------------------------------------------
// gwf_ctrl
// Sequencer: reset clearing pass, operation decode, sweeps and per-cell
// steps, and the result handshake.
// ----------------------------------------------------------------------------
module gwf_ctrl import gwf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DEC     = 4'd2;
  localparam logic [3:0] S_TW      = 4'd3;
  localparam logic [3:0] S_SWEEP   = 4'd4;
  localparam logic [3:0] S_RR_INIT = 4'd5;
  localparam logic [3:0] S_RR_CELL = 4'd6;
  localparam logic [3:0] S_RR_CHK  = 4'd7;
  localparam logic [3:0] S_RR_DIV  = 4'd8;
  localparam logic [3:0] S_RR_WR   = 4'd9;
  localparam logic [3:0] S_FL_RD   = 4'd10;
  localparam logic [3:0] S_FL_UPD  = 4'd11;
  localparam logic [3:0] S_RD      = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  logic [3:0]        state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [3:0]        sub_q, sub_d;
  logic [2:0]        mode_q, mode_d;
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] cnt_inc, fl_next;

  assign cnt_inc = cnt_q + ADDR_W'(1);
  assign fl_next = (cnt_q[X_W-1:0] == FL_X_LAST) ? cnt_q + ADDR_W'(3) : cnt_inc;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sub_d       = sub_q;
    mode_d      = mode_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.addr  = cnt_q;
    cmd_o.mode  = mode_q;
    in_ready_o  = 1'b0;

    if (out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep_en = 1'b1;
        cnt_d = cnt_inc;
        if (cnt_q == LAST_CELL) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.in_load = in_valid_i;
        if (in_valid_i) state_d = S_DEC;
      end
      S_DEC: begin
        cnt_d = '0;
        case (sts_i.kind)
          K_TERRAIN: state_d = S_TW;
          K_RAIN: begin
            mode_d  = MD_RAIN;
            state_d = S_SWEEP;
          end
          K_RADIAL: state_d = S_RR_INIT;
          K_CLEAR: begin
            mode_d  = MD_CLEAR;
            state_d = S_SWEEP;
          end
          K_FLOW: begin
            mode_d  = MD_COPY;
            state_d = S_SWEEP;
          end
          K_READ:  state_d = S_RD;
          default: state_d = S_DONE;
        endcase
      end
      S_TW: begin
        cmd_o.tw_we = 1'b1;
        state_d = S_DONE;
      end
      S_SWEEP: begin
        cmd_o.sweep_en = 1'b1;
        cnt_d = cnt_inc;
        if (cnt_q == LAST_CELL) begin
          if (mode_q == MD_COPY) begin
            cnt_d   = FL_FIRST;
            sub_d   = '0;
            state_d = S_FL_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_RR_INIT: begin
        cmd_o.rr_init = 1'b1;
        state_d = S_RR_CELL;
      end
      S_RR_CELL: begin
        cmd_o.rr_cell = 1'b1;
        state_d = S_RR_CHK;
      end
      S_RR_CHK: begin
        if (sts_i.rr_in) begin
          cmd_o.rr_start = 1'b1;
          state_d = S_RR_DIV;
        end else begin
          cnt_d   = cnt_inc;
          state_d = (cnt_q == LAST_CELL) ? S_DONE : S_RR_CELL;
        end
      end
      S_RR_DIV: begin
        if (!sts_i.div_busy) state_d = S_RR_WR;
      end
      S_RR_WR: begin
        cmd_o.rr_write = 1'b1;
        cnt_d   = cnt_inc;
        state_d = (cnt_q == LAST_CELL) ? S_DONE : S_RR_CELL;
      end
      S_FL_RD: begin
        cmd_o.fl_rd = sub_q != 4'd5;
        cmd_o.nb    = sub_q[2:0];
        sub_d = sub_q + 4'd1;
        if (sub_q == 4'd5) begin
          sub_d   = '0;
          state_d = S_FL_UPD;
        end
      end
      S_FL_UPD: begin
        cmd_o.fl_ud_rd = !sub_q[0];
        cmd_o.fl_ud_wr = sub_q[0];
        cmd_o.nb       = sub_q[3:1];
        sub_d = sub_q + 4'd1;
        if (sub_q == 4'd9) begin
          sub_d = '0;
          if (cnt_q == FL_LAST) begin
            cnt_d   = '0;
            mode_d  = MD_FIN;
            state_d = S_SWEEP;
          end else begin
            cnt_d   = fl_next;
            state_d = S_FL_RD;
          end
        end
      end
      S_RD: begin
        cmd_o.rd_water = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      sub_q       <= '0;
      mode_q      <= MD_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sub_q       <= sub_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/grid_water_flow_step_top.sv
// ----------------------------------------------------------------------------
// grid_water_flow_step_top
// Terrain and water maps on a 64x64 grid with rain, clear, flow and read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one operation per transfer;
//   output channel (out_valid_o/out_ready_i) returns exactly one result per
//   operation: the water level for a read (else zero) and the kind handled.
//   cfg_we_i writes flow_speed (index 0) or infiltration (index 1) at once;
//   write only while no operation is in flight.
// Steps per operation, from input transfer to result valid:
//   terrain write, read: decode, then the write or read; unknown kind: decode
//   uniform rain, clear: a sweep over every cell, one cell per cycle
//   radial rain: a read and range check per cell, plus a serial division and a
//   write per wetted cell; flow step: a copy sweep, a per-cell interior pass
//   and a finish sweep; the interior pass is bound by one memory port per map.
// One operation is worked at a time; the next is taken while a result still
// waits in the output register, and the finished one holds until taken.
// Reset: a clearing pass over every cell zeroes terrain and water; no input
// is accepted meanwhile, configuration writes are.
// ----------------------------------------------------------------------------
module grid_water_flow_step_top import gwf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         in_kind_i,
  input  logic [X_W-1:0]     in_cell_x_i,
  input  logic [Y_W-1:0]     in_cell_y_i,
  input  logic signed [15:0] in_terrain_height_i,
  input  logic [15:0]        in_rain_amount_i,
  input  logic [11:0]        in_rain_radius_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        out_water_level_o,
  output logic [2:0]         out_done_kind_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  cmd_t cmd;   // sequencer -> datapath
  sts_t sts;   // datapath -> sequencer

  gwf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gwf_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .in_kind_i          (in_kind_i),
    .in_cell_x_i        (in_cell_x_i),
    .in_cell_y_i        (in_cell_y_i),
    .in_terrain_height_i(in_terrain_height_i),
    .in_rain_amount_i   (in_rain_amount_i),
    .in_rain_radius_i   (in_rain_radius_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .out_water_level_o  (out_water_level_o),
    .out_done_kind_o    (out_done_kind_o)
  );

  // an accepted transfer moves the sequencer out of idle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready after transfer");

  // the divider only runs inside a radial rain operation
  a_div_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.div_busy |-> !in_ready_o)
    else $error("divider busy while idle");

  // only a read returns a nonzero level
  a_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_done_kind_o != K_READ) |-> out_water_level_o == 16'd0)
    else $error("nonzero level for non-read");

endmodule
